/* rtl/utf8_codec_core_assert.svh */
// ---------------------------------------------------------------------------
// utf8 codec assertion macros
// shared property wrappers clocked on aclk, disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef UTF8_CODEC_CORE_ASSERT_SVH
`define UTF8_CODEC_CORE_ASSERT_SVH

// same-cycle implication
`define UTF8C_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("utf8 codec check failed");

// next-cycle implication
`define UTF8C_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("utf8 codec check failed");

`endif

/* rtl/utf8c_pkg.sv */
// ---------------------------------------------------------------------------
// utf8c_pkg
// shared types and codes for the utf-8 codec
// ---------------------------------------------------------------------------
`default_nettype none

package utf8c_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 3;

    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    localparam logic KIND_DECODE = 1'b0;
    localparam logic KIND_ENCODE = 1'b1;

    localparam logic [CP_W-1:0] CP_MAX_1B = 21'h00007F;
    localparam logic [CP_W-1:0] CP_MAX_2B = 21'h0007FF;
    localparam logic [CP_W-1:0] CP_MAX_3B = 21'h00FFFF;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_TERM     = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef struct packed {
        logic              kind;
        status_t           status;
        logic [CP_W-1:0]   code_point;
        logic [LEN_W-1:0]  seq_len;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/utf8c_dec.sv */
// ---------------------------------------------------------------------------
// utf8c_dec
// byte-serial utf-8 decoder: lead classification and continuation gathering
// ---------------------------------------------------------------------------
`default_nettype none

module utf8c_dec (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    step,      // byte consumed this cycle
    input  wire logic [7:0]              byte_in,
    output utf8c_pkg::result_t           result,
    output logic                         has_result
);
    import utf8c_pkg::*;

    logic [1:0]      rem_reg, rem_next;
    logic [2:0]      total_reg, total_next;
    logic [CP_W-1:0] acc_reg, acc_next;
    logic [CP_W-1:0] acc_shift;
    logic [1:0]      rem_dec;

    assign acc_shift = {acc_reg[CP_W-7:0], byte_in[5:0]};
    assign rem_dec   = rem_reg - 2'd1;

    always_comb begin
        rem_next          = rem_reg;
        total_next        = total_reg;
        acc_next          = acc_reg;
        has_result        = 1'b0;
        result.kind       = KIND_DECODE;
        result.status     = ST_OK;
        result.code_point = '0;
        result.seq_len    = '0;
        result.data_byte  = '0;
        result.last       = 1'b1;
        if (rem_reg != 2'd0) begin
            // continuation: low 6 bits taken unchecked
            rem_next = rem_dec;
            if (rem_dec == 2'd0) begin
                has_result        = 1'b1;
                result.code_point = acc_shift;
                result.seq_len    = total_reg;
                total_next        = '0;
                acc_next          = '0;
            end else begin
                acc_next = acc_shift;
            end
        end else if (byte_in == 8'h00) begin
            has_result    = 1'b1;
            result.status = ST_TERM;
        end else if (!byte_in[7]) begin
            has_result        = 1'b1;
            result.code_point = CP_W'(byte_in);
            result.seq_len    = 3'd1;
        end else if (byte_in[7:5] == 3'b110) begin
            acc_next   = CP_W'(byte_in[4:0]);
            total_next = 3'd2;
            rem_next   = 2'd1;
        end else if (byte_in[7:4] == 4'b1110) begin
            acc_next   = CP_W'(byte_in[3:0]);
            total_next = 3'd3;
            rem_next   = 2'd2;
        end else if (byte_in[7:3] == 5'b11110) begin
            acc_next   = CP_W'(byte_in[2:0]);
            total_next = 3'd4;
            rem_next   = 2'd3;
        end else begin
            has_result    = 1'b1;
            result.status = ST_BAD_LEAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg   <= '0;
            total_reg <= '0;
            acc_reg   <= '0;
        end else if (step) begin
            rem_reg   <= rem_next;
            total_reg <= total_next;
            acc_reg   <= acc_next;
        end
    end

`include "utf8_codec_core_assert.svh"

    // a pending sequence always has more bytes in total than still to come
    `UTF8C_ASSERT_IMPL(a_dec_rem_below_total, rem_reg != 2'd0, total_reg > {1'b0, rem_reg})

endmodule

`default_nettype wire

/* rtl/utf8c_enc.sv */
// ---------------------------------------------------------------------------
// utf8c_enc
// utf-8 encoder: one output byte of a code point per byte index
// ---------------------------------------------------------------------------
`default_nettype none

module utf8c_enc (
    input  wire logic [utf8c_pkg::CP_W-1:0] code_point,
    input  wire logic [1:0]                 byte_idx,
    output utf8c_pkg::result_t              result
);
    import utf8c_pkg::*;

    logic [LEN_W-1:0] n;
    logic [1:0]       grp;
    logic [5:0]       bits6;
    logic [7:0]       lead;

    always_comb begin
        if (code_point <= CP_MAX_1B) begin
            n    = 3'd1;
            lead = code_point[7:0];
        end else if (code_point <= CP_MAX_2B) begin
            n    = 3'd2;
            lead = {3'b110, code_point[10:6]};
        end else if (code_point <= CP_MAX_3B) begin
            n    = 3'd3;
            lead = {4'b1110, code_point[15:12]};
        end else begin
            n    = 3'd4;
            lead = {5'b11110, code_point[20:18]};
        end
    end

    // 6-bit group still to send after this byte
    assign grp = 2'(n - 3'd1 - {1'b0, byte_idx});

    always_comb begin
        case (grp)
            2'd0:    bits6 = code_point[5:0];
            2'd1:    bits6 = code_point[11:6];
            2'd2:    bits6 = code_point[17:12];
            default: bits6 = code_point[5:0];
        endcase
    end

    always_comb begin
        result.kind       = KIND_ENCODE;
        result.code_point = '0;
        if (code_point > CP_MAX) begin
            result.status    = ST_RANGE;
            result.seq_len   = '0;
            result.data_byte = '0;
            result.last      = 1'b1;
        end else begin
            result.status    = ST_OK;
            result.seq_len   = n;
            result.data_byte = (byte_idx == 2'd0) ? lead : {2'b10, bits6};
            result.last      = ({1'b0, byte_idx} == (n - 3'd1));
        end
    end

endmodule

`default_nettype wire

/* rtl/utf8_codec_core.sv */
// ---------------------------------------------------------------------------
// utf8_codec_core
// utf-8 stream decoder and code point encoder behind one request port
// ---------------------------------------------------------------------------
// Each request either decodes one byte (tuser 0) or encodes one code point
// (tuser 1). Decode requests are taken one per cycle, but a byte that gives a
// result waits while the result register holds an untaken result; a lead
// byte of a multi-byte sequence and every continuation byte except the last
// give no result, the final byte gives the code point and its length. Zero
// bytes give a terminator status, stray bytes an invalid-lead status. An
// encode request gives one result per output byte (one for an out-of-range
// code point), stepped by the encoder's byte index counter, and holds the
// input register until its last byte is out; the next request is taken in
// the cycle its last byte moves to the result register. The result register
// parts the two sides: a waiting result does not stop a request that gives
// no result. Overlong forms and surrogates pass through unchecked; an encode
// request pending between decode bytes leaves the decode sequence intact.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_codec_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [7:0] byte_in, [28:8] code_point_in, [31:29] zero
    input  wire logic        s_tuser,   // [0] command
    // result side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [1:0] status, [22:2] code_point_out,
                                        // [25:23] sequence_length, [33:26] byte_out,
                                        // [39:34] zero
    output logic             m_tuser,   // [0] result_kind
    output logic             m_tlast    // last result of the request
);
    import utf8c_pkg::*;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic              in_cmd_reg;
    logic [7:0]        in_byte_reg;
    logic [CP_W-1:0]   in_cp_reg;
    logic              in_load;

    // encode byte index
    logic [1:0]        idx_reg, idx_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    // step logic
    result_t           dec_result, enc_result, step_result;
    logic              dec_has_result, has_result;
    logic              out_free, step, item_done, dec_step;

    assign out_free    = !out_valid_reg || m_tready;
    assign has_result  = (in_cmd_reg == CMD_ENCODE) ? 1'b1 : dec_has_result;
    // requests with no result never wait on the output
    assign step        = in_valid_reg && (!has_result || out_free);
    assign dec_step    = step && (in_cmd_reg == CMD_DECODE);
    assign step_result = (in_cmd_reg == CMD_ENCODE) ? enc_result : dec_result;
    assign item_done   = step && step_result.last;
    assign s_tready    = !in_valid_reg || item_done;
    assign in_load     = s_tvalid && s_tready;

    utf8c_dec u_dec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (dec_step),
        .byte_in    (in_byte_reg),
        .result     (dec_result),
        .has_result (dec_has_result)
    );

    utf8c_enc u_enc (
        .code_point (in_cp_reg),
        .byte_idx   (idx_reg),
        .result     (enc_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (step && (in_cmd_reg == CMD_ENCODE)) begin
            idx_next = enc_result.last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step && has_result) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
            in_cp_reg   <= s_tdata[28:8];
        end
        if (step && has_result) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {6'b0, out_reg.data_byte, out_reg.seq_len,
                       out_reg.code_point, out_reg.status};

`include "utf8_codec_core_assert.svh"

    // a nonzero byte index only exists while an encode request is held
    `UTF8C_ASSERT_IMPL(a_idx_only_in_encode, idx_reg != 2'd0,
        in_valid_reg && (in_cmd_reg == CMD_ENCODE))
    // the input only stalls when it holds a request
    `UTF8C_ASSERT_IMPL(a_stall_means_full, !s_tready, in_valid_reg)
    // a good decode result always carries a length of one to four
    `UTF8C_ASSERT_IMPL(a_dec_ok_len,
        m_tvalid && (m_tuser == KIND_DECODE) && (m_tdata[1:0] == ST_OK),
        (m_tdata[25:23] != 3'd0) && (m_tdata[25:23] <= 3'd4))
    // an encoded byte that is not last belongs to a multi-byte sequence
    `UTF8C_ASSERT_IMPL(a_enc_mid_multi, m_tvalid && (m_tuser == KIND_ENCODE) && !m_tlast,
        (m_tdata[1:0] == ST_OK) && (m_tdata[25:23] >= 3'd2))
    // a non-last encoded byte is followed by the next byte of the same request
    `UTF8C_ASSERT_NEXT(a_enc_followup,
        step && (in_cmd_reg == CMD_ENCODE) && !enc_result.last,
        in_valid_reg && (in_cmd_reg == CMD_ENCODE) && (idx_reg != 2'd0))

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// utf8_codec_core testbench
// streams decode bytes and encode requests through the codec and checks every
// result, field by field, against an in-order prediction of the codec
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

    import utf8c_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;

    typedef struct {
        logic              cmd;
        logic [BYTE_W-1:0] data_byte;
        logic [CP_W-1:0]   cp;
    } codec_req_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    codec_req_t  request_q[$];
    codec_req_t  cur_req;
    result_t     awaited_results[$];

    // decoder state as the codec should hold it
    logic [1:0]      cont_left  = '0;
    logic [LEN_W-1:0] seq_total = '0;
    logic [CP_W-1:0] cp_accum   = '0;

    int unsigned send_idle_pct = 21;
    int unsigned recv_idle_pct = 81;
    int unsigned fault_count   = 0;
    int unsigned cycle_count   = 0;

    utf8_codec_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic result_t make_result(logic kind, status_t st, logic [CP_W-1:0] cp,
                                            logic [LEN_W-1:0] len, logic [BYTE_W-1:0] b,
                                            logic fin);
        result_t r;
        r.kind       = kind;
        r.status     = st;
        r.code_point = cp;
        r.seq_len    = len;
        r.data_byte  = b;
        r.last       = fin;
        return r;
    endfunction

    // works out the results one accepted request causes
    task automatic compute_utf8_results(codec_req_t rq);
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] lead;
        logic [CP_W-1:0]   cp;
        int                n;
        b  = rq.data_byte;
        cp = rq.cp;
        if (rq.cmd == CMD_DECODE) begin
            if (cont_left != 0) begin
                // continuation bytes are taken as their low six bits, unchecked
                cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 0) begin
                    awaited_results.push_back(make_result(KIND_DECODE, ST_OK, cp_accum,
                                                          seq_total, '0, 1'b1));
                    seq_total = '0;
                    cp_accum  = '0;
                end
            end else if (b == 8'h00) begin
                awaited_results.push_back(make_result(KIND_DECODE, ST_TERM, '0, '0, '0, 1'b1));
            end else if (!b[7]) begin
                awaited_results.push_back(make_result(KIND_DECODE, ST_OK, {13'd0, b}, 3'd1,
                                                      '0, 1'b1));
            end else if ((b & 8'hE0) == 8'hC0) begin
                cp_accum  = {16'd0, b[4:0]};
                seq_total = 3'd2;
                cont_left = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
                cp_accum  = {17'd0, b[3:0]};
                seq_total = 3'd3;
                cont_left = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
                cp_accum  = {18'd0, b[2:0]};
                seq_total = 3'd4;
                cont_left = 2'd3;
            end else begin
                awaited_results.push_back(make_result(KIND_DECODE, ST_BAD_LEAD, '0, '0, '0,
                                                      1'b1));
            end
        end else begin
            // encoder leaves the decoder state alone
            if (cp > CP_MAX) begin
                awaited_results.push_back(make_result(KIND_ENCODE, ST_RANGE, '0, '0, '0, 1'b1));
            end else if (cp <= CP_MAX_1B) begin
                awaited_results.push_back(make_result(KIND_ENCODE, ST_OK, '0, 3'd1, cp[7:0],
                                                      1'b1));
            end else begin
                if (cp <= CP_MAX_2B) begin
                    n    = 2;
                    lead = 8'hC0 | {3'd0, cp[10:6]};
                end else if (cp <= CP_MAX_3B) begin
                    n    = 3;
                    lead = 8'hE0 | {4'd0, cp[15:12]};
                end else begin
                    n    = 4;
                    lead = 8'hF0 | {5'd0, cp[20:18]};
                end
                awaited_results.push_back(make_result(KIND_ENCODE, ST_OK, '0, LEN_W'(n), lead,
                                                      1'b0));
                for (int i = 1; i < n; i++) begin
                    awaited_results.push_back(make_result(KIND_ENCODE, ST_OK, '0, LEN_W'(n),
                        8'h80 | {2'd0, 6'((cp >> (6 * (n - 1 - i))) & 21'h3F)},
                        i == n - 1));
                end
            end
        end
    endtask

    // unused field of each request carries random bits
    task automatic push_decode(logic [7:0] b);
        codec_req_t rq;
        rq.cmd       = CMD_DECODE;
        rq.data_byte = b;
        rq.cp        = CP_W'($urandom);
        request_q.push_back(rq);
    endtask

    task automatic push_encode(logic [CP_W-1:0] cp);
        codec_req_t rq;
        rq.cmd       = CMD_ENCODE;
        rq.data_byte = BYTE_W'($urandom);
        rq.cp        = cp;
        request_q.push_back(rq);
    endtask

    function automatic logic [CP_W-1:0] random_code_point();
        case ($urandom_range(5))
            0:       return CP_W'($urandom_range(21'h00007F));
            1:       return CP_W'($urandom_range(21'h0007FF, 21'h000080));
            2:       return CP_W'($urandom_range(21'h00FFFF, 21'h000800));
            3:       return CP_W'($urandom_range(21'h10FFFF, 21'h010000));
            4:       return CP_W'($urandom_range(21'h1FFFFF, 21'h110000));
            default: return CP_W'($urandom);
        endcase
    endfunction

    task automatic load_directed();
        // decode extremes, terminator and stray leads
        push_decode(8'h00);
        push_decode(8'h7F);
        push_decode(8'h80);
        push_decode(8'hF8);
        push_decode(8'hFF);
        // four-byte sequence
        push_decode(8'hF0);
        push_decode(8'h9F);
        push_decode(8'h98);
        push_decode(8'h80);
        // encode dropped into the middle of a three-byte sequence
        push_decode(8'hE2);
        push_encode(21'h0020AC);
        push_decode(8'h82);
        push_decode(8'hAC);
        // continuation with wrong high bits still counts
        push_decode(8'hC3);
        push_decode(8'hFF);
        // encode boundaries, zero and out of range
        push_encode(21'h000000);
        push_encode(21'h00007F);
        push_encode(21'h000080);
        push_encode(21'h0007FF);
        push_encode(21'h000800);
        push_encode(21'h00FFFF);
        push_encode(21'h010000);
        push_encode(21'h10FFFF);
        push_encode(21'h110000);
        push_encode(21'h1FFFFF);
    endtask

    // mostly well-formed sequences with random payload, plus encodes and noise
    task automatic load_random(int count);
        int added;
        int len;
        added = 0;
        while (added < count) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                    len = $urandom_range(1, 4);
                    case (len)
                        1:       push_decode(BYTE_W'($urandom_range(127, 1)));
                        2:       push_decode(8'hC0 | BYTE_W'($urandom_range(31)));
                        3:       push_decode(8'hE0 | BYTE_W'($urandom_range(15)));
                        default: push_decode(8'hF0 | BYTE_W'($urandom_range(7)));
                    endcase
                    added++;
                    for (int i = 1; i < len; i++) begin
                        if ($urandom_range(7) == 0) begin
                            push_encode(random_code_point());
                            added++;
                        end
                        if ($urandom_range(9) == 0)
                            push_decode(BYTE_W'($urandom));
                        else
                            push_decode(8'h80 | BYTE_W'($urandom_range(63)));
                        added++;
                    end
                end
                9, 10, 11, 12, 13, 14, 15: begin
                    push_encode(random_code_point());
                    added++;
                end
                default: begin
                    push_decode(BYTE_W'($urandom));
                    added++;
                end
            endcase
        end
    endtask

    // sender stays quiet until every expected result is back
    task automatic wait_drained();
        while (request_q.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic compare_field(string label, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, label, want, seen);
            fault_count++;
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                compute_utf8_results(cur_req);
            if (!s_tvalid || s_tready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.cmd;
                    s_tdata  <= {3'd0, cur_req.cp, cur_req.data_byte};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin : result_monitor
        result_t seen;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.kind       = m_tuser;
                seen.status     = status_t'(m_tdata[1:0]);
                seen.code_point = m_tdata[22:2];
                seen.seq_len    = m_tdata[25:23];
                seen.data_byte  = m_tdata[33:26];
                seen.last       = m_tlast;
                if (awaited_results.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h", $time, seen);
                    fault_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("result_kind", want.kind, seen.kind);
                    compare_field("status", want.status, seen.status);
                    compare_field("code_point_out", want.code_point, seen.code_point);
                    compare_field("sequence_length", want.seq_len, seen.seq_len);
                    compare_field("byte_out", want.data_byte, seen.data_byte);
                    compare_field("last", want.last, seen.last);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // slow sender, slower receiver
        load_directed();
        wait_drained();
        load_random(28);
        wait_drained();

        // roles swapped
        send_idle_pct = 81;
        recv_idle_pct = 21;
        load_random(28);
        wait_drained();

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_random(28);
        wait_drained();

        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
